// File: rtl/sva_pkg.sv
// ----------------------------------------------------------------------------
// sva_pkg: shared constants and types for the statevector gate unit
// Store geometry, function and status codes, and the controller/datapath
// command and status words.
// ----------------------------------------------------------------------------
package sva_pkg;

	localparam int MAX_QUBITS = 10;
	localparam int AMP_WIDTH  = 16;
	localparam int FRAC_BITS  = AMP_WIDTH - 2;
	localparam int ADDR_W     = MAX_QUBITS;
	localparam int STORE_DEPTH = 1 << MAX_QUBITS;
	localparam int INDEX_W    = 10;
	localparam int QUBIT_W    = 4;
	localparam int FUNC_W     = 3;
	localparam int STATUS_W   = 2;
	localparam int MAT_DEPTH  = 16;
	localparam int MAT_AW     = 4;
	localparam int CPLX_W     = 2 * AMP_WIDTH;

	// function codes
	localparam logic [FUNC_W-1:0] FUNC_WR_MAT = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_WR_AMP = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_GATE1  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_GATE2  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_RD_AMP = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_QUBIT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EQ_QUBIT  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       wr_mat;
		logic       wr_amp;
		logic       rd_idx;
		logic       cap_rd;
		logic       grp_clr;
		logic       grp_inc;
		logic       rd_grp;
		logic       cap_old;
		logic       mat_rd;
		logic       clr_acc;
		logic       mul;
		logic       acc;
		logic       wr_res;
		logic       done;
		logic [1:0] k;
		logic [1:0] c;
		logic [1:0] r;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              err;
		logic              two;
		logic              last_grp;
	} stat_t;

endpackage

// File: rtl/sva_ram.sv
// ----------------------------------------------------------------------------
// sva_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sva_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/sva_ctrl.sv
// ----------------------------------------------------------------------------
// sva_ctrl: sequencer for the statevector gate unit
// Decodes each word and steps the datapath through load, multiply-accumulate
// and write-back for every amplitude group of a gate.
// ----------------------------------------------------------------------------
module sva_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sva_pkg::stat_t stat,
	output sva_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_RWAIT = 4'd2;
	localparam logic [3:0] S_LRD   = 4'd3;
	localparam logic [3:0] S_LCAP  = 4'd4;
	localparam logic [3:0] S_MRD   = 4'd5;
	localparam logic [3:0] S_MMUL  = 4'd6;
	localparam logic [3:0] S_MACC  = 4'd7;
	localparam logic [3:0] S_MWR   = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0] state_q, state_d;
	logic [1:0] k_q, k_d, c_q, c_d, r_q, r_d;
	logic [1:0] m_last;

	// last index within a group: pair or quadruple
	assign m_last = stat.two ? 2'd3 : 2'd1;
	assign busy   = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		c_d     = c_q;
		r_d     = r_q;
		cmd     = '0;
		cmd.k   = k_q;
		cmd.c   = c_q;
		cmd.r   = r_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				k_d = '0;
				c_d = '0;
				r_d = '0;
				state_d = S_DONE;
				if (!stat.err) begin
					unique case (stat.func)
						sva_pkg::FUNC_WR_MAT: cmd.wr_mat = 1'b1;
						sva_pkg::FUNC_WR_AMP: cmd.wr_amp = 1'b1;
						sva_pkg::FUNC_RD_AMP: begin
							cmd.rd_idx = 1'b1;
							state_d    = S_RWAIT;
						end
						sva_pkg::FUNC_GATE1, sva_pkg::FUNC_GATE2: begin
							cmd.grp_clr = 1'b1;
							state_d     = S_LRD;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_RWAIT: begin
				cmd.cap_rd = 1'b1;
				state_d    = S_DONE;
			end
			S_LRD: begin
				cmd.rd_grp = 1'b1;
				state_d    = S_LCAP;
			end
			S_LCAP: begin
				cmd.cap_old = 1'b1;
				if (k_q == m_last) begin
					k_d     = '0;
					state_d = S_MRD;
				end else begin
					k_d     = k_q + 2'd1;
					state_d = S_LRD;
				end
			end
			S_MRD: begin
				cmd.mat_rd  = 1'b1;
				cmd.clr_acc = (c_q == 2'd0);
				state_d     = S_MMUL;
			end
			S_MMUL: begin
				cmd.mul = 1'b1;
				state_d = S_MACC;
			end
			S_MACC: begin
				cmd.acc = 1'b1;
				if (c_q == m_last) begin
					c_d     = '0;
					state_d = S_MWR;
				end else begin
					c_d     = c_q + 2'd1;
					state_d = S_MRD;
				end
			end
			S_MWR: begin
				cmd.wr_res = 1'b1;
				if (r_q == m_last) begin
					r_d = '0;
					if (stat.last_grp) begin
						state_d = S_DONE;
					end else begin
						cmd.grp_inc = 1'b1;
						state_d     = S_LRD;
					end
				end else begin
					r_d     = r_q + 2'd1;
					state_d = S_MRD;
				end
			end
			S_DONE: begin
				cmd.done = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			c_q     <= '0;
			r_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			c_q     <= c_d;
			r_q     <= r_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_idle_counters: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (k_q == 2'd0 && c_q == 2'd0 && r_q == 2'd0))
		else $error("group counters not cleared in idle");
	a_wr_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MWR) |-> $past(state_q == S_MACC))
		else $error("write-back without full accumulation");
	a_load_decode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_DEC))
		else $error("accepted word not decoded");
`endif

endmodule

// File: rtl/sva_dp.sv
// ----------------------------------------------------------------------------
// sva_dp: datapath for the statevector gate unit
// Holds the word, both stores, group addressing, the complex multiplier
// and the rounding, accumulating and saturating logic.
// ----------------------------------------------------------------------------
module sva_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sva_pkg::cmd_t                       cmd,
	output sva_pkg::stat_t                      stat,
	input  logic [sva_pkg::QUBIT_W-1:0]         num_qubits,
	input  logic [sva_pkg::FUNC_W-1:0]          func,
	input  logic [sva_pkg::INDEX_W-1:0]         index,
	input  logic signed [sva_pkg::AMP_WIDTH-1:0] real_part,
	input  logic signed [sva_pkg::AMP_WIDTH-1:0] imag_part,
	input  logic [sva_pkg::QUBIT_W-1:0]         qubit_a,
	input  logic [sva_pkg::QUBIT_W-1:0]         qubit_b,
	output logic                                done,
	output logic signed [sva_pkg::AMP_WIDTH-1:0] read_real,
	output logic signed [sva_pkg::AMP_WIDTH-1:0] read_imag,
	output logic [sva_pkg::STATUS_W-1:0]        status
);

	localparam int AW     = sva_pkg::ADDR_W;
	localparam int CNT_W  = AW + 1;
	localparam int W      = sva_pkg::AMP_WIDTH;
	localparam int PROD_W = 2 * W;
	localparam int RND_W  = PROD_W + 1 - sva_pkg::FRAC_BITS;
	localparam int ACC_W  = RND_W + 4;
	localparam logic signed [ACC_W-1:0] AMP_HI = ACC_W'((2 ** (W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] AMP_LO = -AMP_HI - ACC_W'(1);

	// round to nearest, ties upward: floor((p + half) / 2^F)
	function automatic logic signed [RND_W-1:0] rnd(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W:0] t;
		t = (PROD_W + 1)'(p) + (PROD_W + 1)'(1 << (sva_pkg::FRAC_BITS - 1));
		return RND_W'(t >>> sva_pkg::FRAC_BITS);
	endfunction

	function automatic logic signed [W-1:0] sat(input logic signed [ACC_W-1:0] v);
		if (v > AMP_HI) return W'(AMP_HI);
		if (v < AMP_LO) return W'(AMP_LO);
		return W'(v);
	endfunction

	// insert a zero bit at position p
	function automatic logic [AW-1:0] ins0(input logic [AW-1:0] v,
		input logic [sva_pkg::QUBIT_W-1:0] p);
		logic [AW-1:0] mask;
		mask = ~({AW{1'b1}} << p);
		return ((v & ~mask) << 1) | (v & mask);
	endfunction

	// word registers
	logic [sva_pkg::FUNC_W-1:0]  func_q;
	logic [sva_pkg::INDEX_W-1:0] index_q;
	logic signed [W-1:0]         wr_re_q, wr_im_q;
	logic [sva_pkg::QUBIT_W-1:0] qa_q, qb_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			index_q <= index;
			wr_re_q <= real_part;
			wr_im_q <= imag_part;
			qa_q    <= qubit_a;
			qb_q    <= qubit_b;
		end
	end

	// active qubit count, clamped to 1..MAX_QUBITS
	logic [sva_pkg::QUBIT_W-1:0] n_act;
	always_comb begin
		n_act = num_qubits;
		if (num_qubits == '0) n_act = sva_pkg::QUBIT_W'(1);
		if (num_qubits > sva_pkg::QUBIT_W'(sva_pkg::MAX_QUBITS))
			n_act = sva_pkg::QUBIT_W'(sva_pkg::MAX_QUBITS);
	end

	// status of the held word
	logic [sva_pkg::STATUS_W-1:0] st;
	logic addr_bad, qa_bad, qb_bad;
	assign addr_bad = ((index_q >> n_act) != '0);
	assign qa_bad   = (qa_q >= n_act);
	assign qb_bad   = (qb_q >= n_act);

	always_comb begin
		st = sva_pkg::ST_OK;
		unique case (func_q)
			sva_pkg::FUNC_WR_MAT:
				if (index_q[sva_pkg::INDEX_W-1:sva_pkg::MAT_AW] != '0) st = sva_pkg::ST_BAD_ADDR;
			sva_pkg::FUNC_WR_AMP, sva_pkg::FUNC_RD_AMP:
				if (addr_bad) st = sva_pkg::ST_BAD_ADDR;
			sva_pkg::FUNC_GATE1:
				if (qa_bad) st = sva_pkg::ST_BAD_QUBIT;
			sva_pkg::FUNC_GATE2: begin
				if (qa_bad || qb_bad) st = sva_pkg::ST_BAD_QUBIT;
				else if (qa_q == qb_q) st = sva_pkg::ST_EQ_QUBIT;
			end
			default: st = sva_pkg::ST_OK;
		endcase
	end

	// group counter and addressing
	logic [AW-1:0]    g_q, base, ma, mb, grp_addr, res_addr;
	logic [CNT_W-1:0] size, groups;
	logic [sva_pkg::QUBIT_W-1:0] lo_p, hi_p;
	logic two;

	assign two    = (func_q == sva_pkg::FUNC_GATE2);
	assign size   = CNT_W'(1) << n_act;
	assign groups = two ? (size >> 2) : (size >> 1);
	assign lo_p   = (qa_q < qb_q) ? qa_q : qb_q;
	assign hi_p   = (qa_q < qb_q) ? qb_q : qa_q;
	assign base   = two ? ins0(ins0(g_q, lo_p), hi_p) : ins0(g_q, qa_q);
	assign ma     = AW'(1) << qa_q;
	assign mb     = AW'(1) << qb_q;

	always_comb begin
		if (two) begin
			grp_addr = base | (cmd.k[0] ? mb : '0) | (cmd.k[1] ? ma : '0);
			res_addr = base | (cmd.r[0] ? mb : '0) | (cmd.r[1] ? ma : '0);
		end else begin
			grp_addr = base | (cmd.k[0] ? ma : '0);
			res_addr = base | (cmd.r[0] ? ma : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.grp_clr) g_q <= '0;
		else if (cmd.grp_inc) g_q <= g_q + AW'(1);
	end

	assign stat.func     = func_q;
	assign stat.err      = (st != sva_pkg::ST_OK);
	assign stat.two      = two;
	assign stat.last_grp = ({1'b0, g_q} == groups - CNT_W'(1));

	// amplitude store
	logic                            amp_we;
	logic [AW-1:0]                   amp_waddr, amp_raddr;
	logic [sva_pkg::CPLX_W-1:0]      amp_wdata, amp_rdata;
	logic signed [ACC_W-1:0]         acc_re_q, acc_im_q;

	assign amp_we    = cmd.wr_amp || cmd.wr_res;
	assign amp_waddr = cmd.wr_res ? res_addr : AW'(index_q);
	assign amp_wdata = cmd.wr_res ? {sat(acc_re_q), sat(acc_im_q)} : {wr_re_q, wr_im_q};
	assign amp_raddr = cmd.rd_idx ? AW'(index_q) : grp_addr;

	sva_ram #(.WIDTH(sva_pkg::CPLX_W), .DEPTH(sva_pkg::STORE_DEPTH)) u_amp_ram (
		.clk   (clk),
		.we    (amp_we),
		.waddr (amp_waddr),
		.wdata (amp_wdata),
		.raddr (amp_raddr),
		.rdata (amp_rdata)
	);

	// matrix store, addressed row*4+col
	logic [sva_pkg::CPLX_W-1:0] mat_rdata;

	sva_ram #(.WIDTH(sva_pkg::CPLX_W), .DEPTH(sva_pkg::MAT_DEPTH)) u_mat_ram (
		.clk   (clk),
		.we    (cmd.wr_mat),
		.waddr (index_q[sva_pkg::MAT_AW-1:0]),
		.wdata ({wr_re_q, wr_im_q}),
		.raddr ({cmd.r, cmd.c}),
		.rdata (mat_rdata)
	);

	// old amplitudes of the current group
	logic signed [W-1:0] old_re_q [4];
	logic signed [W-1:0] old_im_q [4];
	always_ff @(posedge clk) begin
		if (cmd.cap_old) begin
			old_re_q[cmd.k] <= amp_rdata[sva_pkg::CPLX_W-1:W];
			old_im_q[cmd.k] <= amp_rdata[W-1:0];
		end
	end

	// complex product terms
	logic signed [W-1:0]      ur, ui, ar, ai;
	logic signed [PROD_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
	assign ur = mat_rdata[sva_pkg::CPLX_W-1:W];
	assign ui = mat_rdata[W-1:0];
	assign ar = old_re_q[cmd.c];
	assign ai = old_im_q[cmd.c];

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			p_rr_q <= ur * ar;
			p_ii_q <= ui * ai;
			p_ri_q <= ur * ai;
			p_ir_q <= ui * ar;
		end
	end

	// exact sum of rounded terms
	always_ff @(posedge clk) begin
		if (cmd.clr_acc) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (cmd.acc) begin
			acc_re_q <= acc_re_q + ACC_W'(rnd(p_rr_q)) - ACC_W'(rnd(p_ii_q));
			acc_im_q <= acc_im_q + ACC_W'(rnd(p_ri_q)) + ACC_W'(rnd(p_ir_q));
		end
	end

	// read-back capture
	logic [sva_pkg::CPLX_W-1:0] rd_q;
	always_ff @(posedge clk) begin
		if (cmd.cap_rd) rd_q <= amp_rdata;
	end

	// result word
	logic                         done_q;
	logic signed [W-1:0]          read_real_q, read_imag_q;
	logic [sva_pkg::STATUS_W-1:0] status_q;
	logic                         show_rd;
	assign show_rd = (func_q == sva_pkg::FUNC_RD_AMP) && (st == sva_pkg::ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.done;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.done) begin
			read_real_q <= show_rd ? rd_q[sva_pkg::CPLX_W-1:W] : '0;
			read_imag_q <= show_rd ? rd_q[W-1:0] : '0;
			status_q    <= st;
		end
	end

	assign done      = done_q;
	assign read_real = read_real_q;
	assign read_imag = read_imag_q;
	assign status    = status_q;

`ifndef NO_ASSERTIONS
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != sva_pkg::ST_OK) |-> (read_real_q == '0 && read_imag_q == '0))
		else $error("failed word carries read data");
`endif

endmodule

// File: rtl/statevector_gate_apply.sv
// ----------------------------------------------------------------------------
// statevector_gate_apply: fixed-point statevector gate unit
// Gates are applied group by group through the single amplitude RAM port
// and the shared complex multiplier.
// One word is taken at a time, none while busy; busy drops in the strobe cycle.
// Reset clears control state and sets num_qubits to 10; stores are undefined.
// ----------------------------------------------------------------------------
module statevector_gate_apply (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [sva_pkg::FUNC_W-1:0]           func,
	input  logic [sva_pkg::INDEX_W-1:0]          index,
	input  logic signed [sva_pkg::AMP_WIDTH-1:0] real_part,
	input  logic signed [sva_pkg::AMP_WIDTH-1:0] imag_part,
	input  logic [sva_pkg::QUBIT_W-1:0]          qubit_a,
	input  logic [sva_pkg::QUBIT_W-1:0]          qubit_b,
	output logic                                 done,
	output logic signed [sva_pkg::AMP_WIDTH-1:0] read_real,
	output logic signed [sva_pkg::AMP_WIDTH-1:0] read_imag,
	output logic [sva_pkg::STATUS_W-1:0]         status,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [2:0]                           paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	logic [sva_pkg::QUBIT_W-1:0] num_qubits_q;
	logic                        sel_nq;
	sva_pkg::cmd_t               cmd;
	sva_pkg::stat_t              stat;

	// register file: num_qubits at byte 0
	assign pready = 1'b1;
	assign sel_nq = (paddr[2] == 1'b0);
	assign prdata = sel_nq ? {{(32 - sva_pkg::QUBIT_W){1'b0}}, num_qubits_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_qubits_q <= sva_pkg::QUBIT_W'(sva_pkg::MAX_QUBITS);
		end else if (psel && penable && pwrite && pready && sel_nq) begin
			num_qubits_q <= pwdata[sva_pkg::QUBIT_W-1:0];
		end
	end

	sva_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	sva_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.num_qubits (num_qubits_q),
		.func       (func),
		.index      (index),
		.real_part  (real_part),
		.imag_part  (imag_part),
		.qubit_a    (qubit_a),
		.qubit_b    (qubit_b),
		.done       (done),
		.read_real  (read_real),
		.read_imag  (read_imag),
		.status     (status)
	);

endmodule

// File: tb/statevector_gate_apply_test.sv
// ----------------------------------------------------------------------------
// statevector_gate_apply_test: self-checking bench for the statevector unit
// Sends matrix/amplitude writes, reads, one- and two-qubit gates and unused
// codes. A local fixed-point model predicts each result word, and each strobed
// result is compared field by field. num_qubits is set over the APB port
// between phases, including its out-of-range settings.
// ----------------------------------------------------------------------------
module statevector_gate_apply_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0]                   REG_NUM_QUBITS = 3'd0;
	localparam logic [sva_pkg::FUNC_W-1:0]   FUNC_SPARE_LO  = 3'd5;
	localparam logic [sva_pkg::FUNC_W-1:0]   FUNC_SPARE_HI  = 3'd7;
	localparam int                           STALL_LIMIT    = 100000;
	localparam int                           DRAIN_CYCLES   = 8;

	typedef struct {
		logic signed [sva_pkg::AMP_WIDTH-1:0] re;
		logic signed [sva_pkg::AMP_WIDTH-1:0] im;
		logic [sva_pkg::STATUS_W-1:0]         st;
	} result_t;

	logic                                 clk, arst_n, start, busy, done;
	logic [sva_pkg::FUNC_W-1:0]           func;
	logic [sva_pkg::INDEX_W-1:0]          index;
	logic signed [sva_pkg::AMP_WIDTH-1:0] real_part, imag_part, read_real, read_imag;
	logic [sva_pkg::QUBIT_W-1:0]          qubit_a, qubit_b;
	logic [sva_pkg::STATUS_W-1:0]         status;
	logic                                 psel, penable, pwrite, pready;
	logic [2:0]                           paddr;
	logic [31:0]                          pwdata, prdata;

	// local copy of the unit's state
	logic signed [sva_pkg::AMP_WIDTH-1:0] amp_re[sva_pkg::STORE_DEPTH];
	logic signed [sva_pkg::AMP_WIDTH-1:0] amp_im[sva_pkg::STORE_DEPTH];
	logic signed [sva_pkg::AMP_WIDTH-1:0] mat_re[sva_pkg::MAT_DEPTH];
	logic signed [sva_pkg::AMP_WIDTH-1:0] mat_im[sva_pkg::MAT_DEPTH];
	bit                                   amp_written[sva_pkg::STORE_DEPTH];
	logic [3:0]                           qubit_count;

	result_t pending_results[$];
	int      errors;
	int      idle_pct;
	int      stall_cycles;

	statevector_gate_apply DUT (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	function automatic longint rnd_mul(longint x, longint y);
		longint p;
		p = x * y + (longint'(1) << (sva_pkg::FRAC_BITS - 1));
		return p >>> sva_pkg::FRAC_BITS;
	endfunction

	function automatic logic signed [sva_pkg::AMP_WIDTH-1:0] clamp(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[sva_pkg::AMP_WIDTH-1:0];
	endfunction

	function automatic int active_qubits();
		if (qubit_count < 1) return 1;
		if (qubit_count > sva_pkg::MAX_QUBITS) return sva_pkg::MAX_QUBITS;
		return int'(qubit_count);
	endfunction

	// map every group of m amplitudes through the matrix
	function automatic void apply_gate(int n, int qa, int qb, int m);
		int     idx[4];
		longint ore[4], oim[4], sr, si;
		for (int i = 0; i < (1 << n); i++) begin
			if (i[qa] || (m == 4 && i[qb])) continue;
			idx[0] = i;
			idx[1] = (m == 4) ? (i | (1 << qb)) : (i | (1 << qa));
			idx[2] = i | (1 << qa);
			idx[3] = i | (1 << qa) | (1 << qb);
			for (int c = 0; c < m; c++) begin
				ore[c] = amp_re[idx[c]];
				oim[c] = amp_im[idx[c]];
			end
			for (int r = 0; r < m; r++) begin
				sr = 0;
				si = 0;
				for (int c = 0; c < m; c++) begin
					sr += rnd_mul(mat_re[r*4+c], ore[c]) - rnd_mul(mat_im[r*4+c], oim[c]);
					si += rnd_mul(mat_re[r*4+c], oim[c]) + rnd_mul(mat_im[r*4+c], ore[c]);
				end
				amp_re[idx[r]] = clamp(sr);
				amp_im[idx[r]] = clamp(si);
			end
		end
	endfunction

	function automatic result_t predict_word(logic [sva_pkg::FUNC_W-1:0] f, int idx,
			logic signed [sva_pkg::AMP_WIDTH-1:0] wr,
			logic signed [sva_pkg::AMP_WIDTH-1:0] wi, int qa, int qb);
		result_t res;
		int      n;
		n = active_qubits();
		res = '{re: '0, im: '0, st: sva_pkg::ST_OK};
		case (f)
			sva_pkg::FUNC_WR_MAT: begin
				if (idx >= sva_pkg::MAT_DEPTH) res.st = sva_pkg::ST_BAD_ADDR;
				else begin
					mat_re[idx] = wr;
					mat_im[idx] = wi;
				end
			end
			sva_pkg::FUNC_WR_AMP: begin
				if (idx >= (1 << n)) res.st = sva_pkg::ST_BAD_ADDR;
				else begin
					amp_re[idx] = wr;
					amp_im[idx] = wi;
					amp_written[idx] = 1'b1;
				end
			end
			sva_pkg::FUNC_GATE1: begin
				if (qa >= n) res.st = sva_pkg::ST_BAD_QUBIT;
				else apply_gate(n, qa, qa, 2);
			end
			sva_pkg::FUNC_GATE2: begin
				if (qa >= n || qb >= n) res.st = sva_pkg::ST_BAD_QUBIT;
				else if (qa == qb) res.st = sva_pkg::ST_EQ_QUBIT;
				else apply_gate(n, qa, qb, 4);
			end
			sva_pkg::FUNC_RD_AMP: begin
				if (idx >= (1 << n)) res.st = sva_pkg::ST_BAD_ADDR;
				else begin
					res.re = amp_re[idx];
					res.im = amp_im[idx];
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				if (read_real !== exp_res.re) begin
					$error("read_real: expected %0d, got %0d", exp_res.re, read_real);
					errors++;
				end
				if (read_imag !== exp_res.im) begin
					$error("read_imag: expected %0d, got %0d", exp_res.im, read_imag);
					errors++;
				end
				if (status !== exp_res.st) begin
					$error("status: expected %0d, got %0d", exp_res.st, status);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles without any word moving
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("statevector_gate_apply_test NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------
	task automatic send_word(logic [sva_pkg::FUNC_W-1:0] f, int idx, int wr, int wi,
			int qa, int qb);
		bit ready;
		func      <= f;
		index     <= idx[sva_pkg::INDEX_W-1:0];
		real_part <= wr[15:0];
		imag_part <= wi[15:0];
		qubit_a   <= qa[sva_pkg::QUBIT_W-1:0];
		qubit_b   <= qb[sva_pkg::QUBIT_W-1:0];
		start     <= 1'b1;
		forever begin
			@(negedge clk);
			ready = !busy;
			@(posedge clk);
			if (ready) break;
		end
		pending_results.push_back(predict_word(f, idx, wr[15:0], wi[15:0], qa, qb));
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	// stop sending and let every expected word arrive
	task automatic settle();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_qubits(logic [3:0] n);
		settle();
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= REG_NUM_QUBITS;
		pwdata  <= {28'd0, n};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		qubit_count = n;
		@(posedge clk);
	endtask

	// write any amplitude of the active store not yet written
	task automatic fill_active();
		for (int i = 0; i < (1 << active_qubits()); i++)
			if (!amp_written[i]) send_word(sva_pkg::FUNC_WR_AMP, i, $urandom, $urandom, 0, 0);
	endtask

	function automatic int written_addr();
		int a;
		do a = $urandom_range((1 << active_qubits()) - 1); while (!amp_written[a]);
		return a;
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		// full matrix, extremes on the diagonal
		for (int i = 0; i < sva_pkg::MAT_DEPTH; i++)
			send_word(sva_pkg::FUNC_WR_MAT, i,
				(i == 0) ? 32'h7fff : (i == 5) ? 32'h8000 : $urandom,
				(i == 15) ? 32'h8000 : $urandom, 0, 0);
		send_word(sva_pkg::FUNC_WR_MAT, 16, 32'h1234, 32'h4321, 0, 0);  // matrix index too big
		send_word(sva_pkg::FUNC_WR_AMP, 1023, 32'h8000, 32'h7fff, 0, 0);
		send_word(sva_pkg::FUNC_RD_AMP, 1023, 0, 0, 0, 0);
		send_word(sva_pkg::FUNC_GATE1, 0, 0, 0, 10, 0);                 // bad qubit
		send_word(sva_pkg::FUNC_GATE2, 0, 0, 0, 15, 15);                // bad beats equal
		send_word(sva_pkg::FUNC_GATE2, 0, 0, 0, 3, 3);                  // equal qubits
		send_word(FUNC_SPARE_LO, 1023, 32'hffff, 32'hffff, 15, 15);
		send_word(FUNC_SPARE_HI, 0, 0, 0, 0, 0);
		set_qubits(4'd2);
		fill_active();
		send_word(sva_pkg::FUNC_GATE1, 0, 0, 0, 1, 0);
		send_word(sva_pkg::FUNC_GATE2, 0, 0, 0, 1, 0);
		send_word(sva_pkg::FUNC_GATE2, 0, 0, 0, 0, 1);
		send_word(sva_pkg::FUNC_RD_AMP, 3, 0, 0, 0, 0);
		send_word(sva_pkg::FUNC_RD_AMP, 4, 0, 0, 0, 0);                 // address out of range
		send_word(sva_pkg::FUNC_WR_AMP, 1023, 0, 0, 0, 0);
	endtask

	task automatic test_register_extremes();
		set_qubits(4'd0);                                              // acts as one qubit
		fill_active();
		send_word(sva_pkg::FUNC_GATE1, 0, 0, 0, 0, 0);
		send_word(sva_pkg::FUNC_GATE1, 0, 0, 0, 1, 0);
		send_word(sva_pkg::FUNC_RD_AMP, 2, 0, 0, 0, 0);
		set_qubits(4'd15);                                             // acts as ten
		send_word(sva_pkg::FUNC_RD_AMP, 1023, 0, 0, 0, 0);
		send_word(sva_pkg::FUNC_GATE2, 0, 0, 0, 9, 9);
		set_qubits(4'd10);
		send_word(sva_pkg::FUNC_GATE1, 0, 0, 0, 12, 0);
		send_word(sva_pkg::FUNC_RD_AMP, 1023, 0, 0, 0, 0);
		set_qubits(4'd1);
	endtask

	task automatic test_random(int words, int pct);
		int n, qa, qb, pick;
		idle_pct = pct;
		for (int w = 0; w < words; w++) begin
			if (w % 40 == 0)
				set_qubits($urandom_range(9) == 0 ? 4'd0 : 4'($urandom_range(6, 1)));
			n = active_qubits();
			pick = $urandom_range(99);
			qa = $urandom_range(n - 1);
			do qb = $urandom_range(n - 1); while (n > 1 && qb == qa);
			if ($urandom_range(99) < 15) begin
				qa = $urandom_range(15);
				qb = $urandom_range(15);
			end
			if (pick < 10)
				send_word(sva_pkg::FUNC_WR_MAT, $urandom_range(99) < 85 ? $urandom_range(15) :
					$urandom_range(1023), $urandom, $urandom, 0, 0);
			else if (pick < 35)
				send_word(sva_pkg::FUNC_WR_AMP, $urandom_range(99) < 85 ?
					$urandom_range((1 << n) - 1) : $urandom_range(1023),
					$urandom, $urandom, $urandom, $urandom);
			else if (pick < 50) begin
				fill_active();
				send_word(sva_pkg::FUNC_GATE1, $urandom, $urandom, $urandom, qa, $urandom);
			end else if (pick < 65) begin
				fill_active();
				send_word(sva_pkg::FUNC_GATE2, $urandom, $urandom, $urandom, qa, qb);
			end else if (pick < 95) begin
				if ($urandom_range(99) < 80) fill_active();
				send_word(sva_pkg::FUNC_RD_AMP, amp_written[0] && $urandom_range(99) < 85 ?
					written_addr() : (1 << n) + $urandom_range(1023 - (1 << n)),
					$urandom, $urandom, $urandom, $urandom);
			end else
				send_word(3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO)), $urandom,
					$urandom, $urandom, $urandom, $urandom);
		end
	endtask

	// sender holds off until the unit has answered everything
	task automatic test_pause();
		fill_active();
		send_word(sva_pkg::FUNC_GATE2, 0, 0, 0, 0, active_qubits() > 1 ? 1 : 0);
		settle();
		send_word(sva_pkg::FUNC_RD_AMP, 0, 0, 0, 0, 0);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		func = '0;
		index = '0;
		real_part = '0;
		imag_part = '0;
		qubit_a = '0;
		qubit_b = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		idle_pct = 0;
		qubit_count = 4'd10;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_register_extremes();
		test_random(130, 0);
		test_random(130, 88);
		test_pause();
		test_random(130, 14);
		test_random(90, 0);

		settle();
		if (errors == 0) $display("statevector_gate_apply_test OK");
		else $display("statevector_gate_apply_test NOT OK");
		$finish;
	end

endmodule

// File: sim.f
rtl/sva_pkg.sv
rtl/sva_ram.sv
rtl/sva_ctrl.sv
rtl/sva_dp.sv
rtl/statevector_gate_apply.sv
tb/statevector_gate_apply_test.sv
